[rtl/ecbu_pkg.sv]
// Package with the shared constants, types and tables of the camera basis update block.
`timescale 1ns / 1ps
package ecbu_pkg;

  localparam int VEC_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam logic [1:0] OP_LOOK    = 2'd0;
  localparam logic [1:0] OP_MOVE    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_SPEED   = 3'd3;
  localparam logic [2:0] REG_SENS    = 3'd4;

  localparam logic [15:0] SPEED_RESET = 16'd640;
  localparam logic [15:0] SENS_RESET  = 16'd6554;

  localparam logic signed [31:0] HALF_TURN = 32'sd11796480;
  localparam logic signed [31:0] FULL_TURN = 32'sd23592960;
  localparam logic signed [31:0] PITCH_LIM = 32'sd5832704;
  localparam logic signed [24:0] YAW_RESET = -25'sd5898240;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] QUARTER_24  = 35'sd1509949440;
  localparam logic signed [34:0] HALF_24     = 35'sd3019898880;
  localparam logic signed [33:0] ONE30       = 34'sd1073741824;

  typedef logic signed [31:0] q30_t;

  function automatic logic signed [31:0] atan_deg24(input logic [4:0] idx);
    logic signed [31:0] r;
    begin
      case (idx)
        5'd0:  r = 32'sd754974720;
        5'd1:  r = 32'sd445687602;
        5'd2:  r = 32'sd235489088;
        5'd3:  r = 32'sd119537938;
        5'd4:  r = 32'sd60000934;
        5'd5:  r = 32'sd30029717;
        5'd6:  r = 32'sd15018523;
        5'd7:  r = 32'sd7509720;
        5'd8:  r = 32'sd3754917;
        5'd9:  r = 32'sd1877466;
        5'd10: r = 32'sd938734;
        5'd11: r = 32'sd469367;
        5'd12: r = 32'sd234684;
        5'd13: r = 32'sd117342;
        5'd14: r = 32'sd58671;
        5'd15: r = 32'sd29335;
        5'd16: r = 32'sd14668;
        5'd17: r = 32'sd7334;
        5'd18: r = 32'sd3667;
        5'd19: r = 32'sd1833;
        5'd20: r = 32'sd917;
        5'd21: r = 32'sd458;
        5'd22: r = 32'sd229;
        5'd23: r = 32'sd115;
        5'd24: r = 32'sd57;
        5'd25: r = 32'sd29;
        5'd26: r = 32'sd14;
        5'd27: r = 32'sd7;
        5'd28: r = 32'sd4;
        5'd29: r = 32'sd2;
        5'd30: r = 32'sd1;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/ecbu_mul.sv]
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module ecbu_mul
  import ecbu_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= 66'(a) * 66'(b);
  end

endmodule

[rtl/ecbu_cordic.sv]
// Iterative CORDIC unit giving the sine and cosine of an angle in degrees.
`timescale 1ns / 1ps
module ecbu_cordic
  import ecbu_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [24:0] angle,
  output logic               done,
  output q30_t               sin_q,
  output q30_t               cos_q
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic              busy_r;
  logic              flip_r;
  logic [CW-1:0]     cnt_r;
  logic signed [33:0] x_r, y_r;
  logic signed [34:0] z_r;
  logic signed [34:0] z0;
  logic signed [33:0] xs, ys, xf, yf;
  logic [4:0]        sh;

  assign z0 = 35'(angle) <<< 8;
  assign sh = 5'(cnt_r);
  assign xs = x_r >>> sh;
  assign ys = y_r >>> sh;
  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;

  function automatic q30_t clamp30(input logic signed [33:0] v);
    begin
      if (v > ONE30) return 32'(ONE30);
      if (v < -ONE30) return -32'(ONE30);
      return 32'(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
      flip_r <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        if (z0 > QUARTER_24) begin
          z_r <= z0 - HALF_24;
          flip_r <= 1'b1;
        end else if (z0 < -QUARTER_24) begin
          z_r <= z0 + HALF_24;
          flip_r <= 1'b1;
        end else begin
          z_r <= z0;
          flip_r <= 1'b0;
        end
      end else if (busy_r) begin
        if (cnt_r == CW'(CORDIC_STEPS)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          sin_q  <= clamp30(yf);
          cos_q  <= clamp30(xf);
        end else begin
          if (!z_r[34]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - 35'(atan_deg24(sh));
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + 35'(atan_deg24(sh));
          end
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/euler_camera_basis_update_top.sv]
// Top level of the first-person camera: sequencer, state, shared units and result register.
`timescale 1ns / 1ps
// The input channel carries one request per event: opcode 0 adds the scaled mouse
// offsets to yaw and pitch and rebuilds the basis, opcode 1 moves the position along
// front and right for the pressed keys, opcode 2 restarts at the configured position.
// Every request gives one result: the position and the nine basis components.
// A request is taken when in_valid is high and in_stall is low; in_stall is high
// while a request is in work. From acceptance to the result, look requests go through
// yaw wrapping and two passes of the shared CORDIC unit; move requests go through the
// seven products on the shared multiplier and the four key steps; restart goes
// straight to the result. The next request can be taken in the cycle after the
// result is loaded. The result waits in an output register while out_stall is high;
// the next request may be taken and worked on meanwhile and is held until the
// register frees. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while idle; the block does not enforce this. A synchronous reset
// sets yaw to -90 degrees, pitch to zero, the position to zero, the basis to front -z,
// right +x, up +y, and the registers to their defaults.
module euler_camera_basis_update_top
  import ecbu_pkg::*;
#(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_look_dx,
  input  logic signed [15:0] in_look_dy,
  input  logic [3:0]         in_key_mask,
  input  logic [15:0]        in_frame_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z
);

  localparam int BW    = VEC_FRAC_BITS + 2;
  localparam int SH    = 30 - VEC_FRAC_BITS;
  localparam int SH_MV = 8 + VEC_FRAC_BITS;
  localparam logic signed [34:0] ONE_V = 35'sd1 <<< VEC_FRAC_BITS;
  localparam logic signed [34:0] RND =
    (SH > 0) ? (35'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 35'sd0;
  localparam logic signed [65:0] HALF_MV = 66'sd1 <<< (SH_MV - 1);
  localparam logic signed [BW-1:0] V_ONE = BW'(ONE_V);

  typedef enum logic [3:0] {
    S_IDLE, S_LK_DX, S_LK_DY, S_LK_PIT, S_WRAP, S_CY, S_CP, S_BM,
    S_MV_DIST, S_MV_CAP, S_MV_PROD, S_KEY, S_DONE
  } state_t;

  state_t state_r;
  logic [2:0]  cnt_r;
  logic signed [15:0] dx_r, dy_r;
  logic [3:0]  keys_r;
  logic [15:0] dt_r;
  logic signed [31:0] start_r [3];
  logic [15:0] speed_r, sens_r;
  logic signed [24:0] yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [31:0] wrap_r;
  logic signed [31:0] pos_r [3];
  logic signed [BW-1:0] basis_r [9];
  q30_t sy_r, cy_r, sp_r, cp_r;
  logic signed [32:0] dist_r;
  logic signed [25:0] dlt_r [6];
  logic out_valid_r;
  logic signed [31:0] opos_r [3];
  logic signed [15:0] obas_r [9];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic cor_start, cor_done;
  logic signed [24:0] cor_angle;
  q30_t cor_sin, cor_cos;
  logic signed [31:0] look_d;
  logic signed [31:0] pit_sum;
  logic signed [33:0] m30;
  logic signed [25:0] mv_d;
  logic ld;

  ecbu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  ecbu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(cor_angle),
    .done(cor_done), .sin_q(cor_sin), .cos_q(cor_cos)
  );

  function automatic logic signed [BW-1:0] to_vec(input logic signed [33:0] q);
    logic signed [34:0] v;
    begin
      v = (35'(q) + RND) >>> SH;
      if (v > ONE_V) v = ONE_V;
      if (v < -ONE_V) v = -ONE_V;
      return BW'(v);
    end
  endfunction

  function automatic logic signed [BW-1:0] home_vec(input int k);
    begin
      if (k == 2) return -V_ONE;
      if (k == 3 || k == 7) return V_ONE;
      return '0;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    begin
      if (v > 33'sd2147483647) return 32'sh7fffffff;
      if (v < -33'sd2147483648) return 32'sh80000000;
      return 32'(v);
    end
  endfunction

  assign look_d  = 32'((prod + 66'sd8) >>> 4);
  assign pit_sum = 32'(pitch_r) + look_d;
  assign m30     = 34'((prod + (66'sd1 <<< 29)) >>> 30);
  assign mv_d    = 26'((prod + HALF_MV) >>> SH_MV);
  assign ld      = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LK_DX: begin
        mul_a = 33'(dx_r);
        mul_b = 33'(sens_r);
      end
      S_LK_DY: begin
        mul_a = 33'(dy_r);
        mul_b = 33'(sens_r);
      end
      S_BM: begin
        case (cnt_r)
          3'd0: begin mul_a = 33'(cy_r); mul_b = 33'(cp_r); end
          3'd1: begin mul_a = 33'(sy_r); mul_b = 33'(cp_r); end
          3'd2: begin mul_a = 33'(cy_r); mul_b = 33'(sp_r); end
          3'd3: begin mul_a = 33'(sy_r); mul_b = 33'(sp_r); end
          default: ;
        endcase
      end
      S_MV_DIST: begin
        mul_a = 33'(speed_r);
        mul_b = 33'(dt_r);
      end
      S_MV_PROD: begin
        if (cnt_r < 3'd6) begin
          mul_a = dist_r;
          mul_b = 33'(basis_r[4'(cnt_r)]);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cor_start = 1'b0;
    cor_angle = yaw_r;
    if (state_r == S_WRAP && wrap_r >= 32'sd0 && wrap_r < FULL_TURN) begin
      cor_start = 1'b1;
      cor_angle = 25'(wrap_r - HALF_TURN);
    end else if (state_r == S_CY && cor_done) begin
      cor_start = 1'b1;
      cor_angle = 25'(pitch_r);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_pos_x = opos_r[0];
  assign out_pos_y = opos_r[1];
  assign out_pos_z = opos_r[2];
  assign out_front_x = obas_r[0];
  assign out_front_y = obas_r[1];
  assign out_front_z = obas_r[2];
  assign out_right_x = obas_r[3];
  assign out_right_y = obas_r[4];
  assign out_right_z = obas_r[5];
  assign out_up_x = obas_r[6];
  assign out_up_y = obas_r[7];
  assign out_up_z = obas_r[8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      start_r[0]  <= '0;
      start_r[1]  <= '0;
      start_r[2]  <= '0;
      speed_r     <= SPEED_RESET;
      sens_r      <= SENS_RESET;
      yaw_r       <= YAW_RESET;
      pitch_r     <= '0;
      for (int k = 0; k < 3; k++) pos_r[k] <= '0;
      for (int k = 0; k < 9; k++) basis_r[k] <= home_vec(k);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X: start_r[0] <= cfg_data;
          REG_START_Y: start_r[1] <= cfg_data;
          REG_START_Z: start_r[2] <= cfg_data;
          REG_SPEED:   speed_r <= cfg_data[15:0];
          REG_SENS:    sens_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dx_r   <= in_look_dx;
            dy_r   <= in_look_dy;
            keys_r <= in_key_mask;
            dt_r   <= in_frame_time;
            case (in_opcode)
              OP_LOOK: state_r <= S_LK_DX;
              OP_MOVE: state_r <= S_MV_DIST;
              OP_RESTART: begin
                for (int k = 0; k < 3; k++) pos_r[k] <= start_r[k];
                yaw_r   <= YAW_RESET;
                pitch_r <= '0;
                for (int k = 0; k < 9; k++) basis_r[k] <= home_vec(k);
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_LK_DX: state_r <= S_LK_DY;
        S_LK_DY: begin
          wrap_r  <= 32'(yaw_r) + look_d + HALF_TURN;
          state_r <= S_LK_PIT;
        end
        S_LK_PIT: begin
          if (pit_sum > PITCH_LIM) pitch_r <= 24'(PITCH_LIM);
          else if (pit_sum < -PITCH_LIM) pitch_r <= 24'(-PITCH_LIM);
          else pitch_r <= 24'(pit_sum);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          if (wrap_r >= FULL_TURN) wrap_r <= wrap_r - FULL_TURN;
          else if (wrap_r < 32'sd0) wrap_r <= wrap_r + FULL_TURN;
          else begin
            yaw_r   <= 25'(wrap_r - HALF_TURN);
            state_r <= S_CY;
          end
        end
        S_CY: begin
          if (cor_done) begin
            sy_r    <= cor_sin;
            cy_r    <= cor_cos;
            state_r <= S_CP;
          end
        end
        S_CP: begin
          if (cor_done) begin
            sp_r    <= cor_sin;
            cp_r    <= cor_cos;
            cnt_r   <= '0;
            state_r <= S_BM;
          end
        end
        S_BM: begin
          cnt_r <= cnt_r + 1'b1;
          case (cnt_r)
            3'd1: basis_r[0] <= to_vec(m30);
            3'd2: basis_r[2] <= to_vec(m30);
            3'd3: basis_r[6] <= to_vec(-m30);
            3'd4: begin
              basis_r[8] <= to_vec(-m30);
              basis_r[1] <= to_vec(34'(sp_r));
              basis_r[3] <= to_vec(-34'(sy_r));
              basis_r[4] <= '0;
              basis_r[5] <= to_vec(34'(cy_r));
              basis_r[7] <= to_vec(34'(cp_r));
              state_r    <= S_DONE;
            end
            default: ;
          endcase
        end
        S_MV_DIST: state_r <= S_MV_CAP;
        S_MV_CAP: begin
          dist_r  <= 33'(prod);
          cnt_r   <= '0;
          state_r <= S_MV_PROD;
        end
        S_MV_PROD: begin
          if (cnt_r != 3'd0) dlt_r[cnt_r - 3'd1] <= mv_d;
          if (cnt_r == 3'd6) begin
            cnt_r   <= '0;
            state_r <= S_KEY;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_KEY: begin
          if (keys_r[cnt_r[1:0]]) begin
            for (int k = 0; k < 3; k++) begin
              case (cnt_r[1:0])
                2'd0: pos_r[k] <= sat32(33'(pos_r[k]) + 33'(dlt_r[k]));
                2'd1: pos_r[k] <= sat32(33'(pos_r[k]) - 33'(dlt_r[k]));
                2'd2: pos_r[k] <= sat32(33'(pos_r[k]) - 33'(dlt_r[k + 3]));
                default: pos_r[k] <= sat32(33'(pos_r[k]) + 33'(dlt_r[k + 3]));
              endcase
            end
          end
          if (cnt_r[1:0] == 2'd3) state_r <= S_DONE;
          cnt_r <= cnt_r + 1'b1;
        end
        S_DONE: begin
          if (ld) begin
            for (int k = 0; k < 3; k++) opos_r[k] <= pos_r[k];
            for (int k = 0; k < 9; k++) obas_r[k] <= 16'(basis_r[k]);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
